>>> rtl/sphere_pair_collision_resolve_unit_defines.svh
// assertion macros for the sphere pair collision resolve unit
`ifndef SPHERE_PAIR_COLLISION_RESOLVE_UNIT_DEFINES_SVH
`define SPHERE_PAIR_COLLISION_RESOLVE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SPCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spcr_pkg.sv
// types, constants and helper functions of the sphere pair collision resolve unit
`default_nettype none

package spcr_pkg;

    // component format
    localparam int CW         = 21;
    localparam int FIELD_W    = 63;
    localparam int RAD_W      = 20;
    localparam int NORM_BITS  = 16;
    localparam int REST_BITS  = 8;
    localparam int REST_W     = 9;
    localparam logic [REST_W-1:0] REST_RESET = 9'd205;

    // internal widths
    localparam int DW         = CW + 1;             // center difference, relative velocity
    localparam int SQ_W       = 2 * CW;             // squared distance when overlapping
    localparam int SQ_STEPS   = CW;                 // one root bit per stage
    localparam int DIV_STEPS  = NORM_BITS + 1;      // quotient bits of the normal
    localparam int NW         = NORM_BITS + 2;      // signed normal component
    localparam int PIPE_DEPTH = 3 + SQ_STEPS + DIV_STEPS + 6;

    typedef struct packed {
        logic [FIELD_W-1:0] pos_a;
        logic [FIELD_W-1:0] vel_a;
        logic [RAD_W-1:0]   radius_a;
        logic [FIELD_W-1:0] pos_b;
        logic [FIELD_W-1:0] vel_b;
        logic [RAD_W-1:0]   radius_b;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] new_pos_a;
        logic [FIELD_W-1:0] new_vel_a;
        logic [FIELD_W-1:0] new_pos_b;
        logic [FIELD_W-1:0] new_vel_b;
        logic               collided;
    } out_item_t;

    // side data carried alongside the square root
    typedef struct packed {
        logic               col;
        logic [2:0][DW-1:0] d;
        logic [2:0][DW-1:0] vrel;
        logic [CW-1:0]      rsum;
        in_item_t           io;
    } root_side_t;

    // side data carried alongside the dividers
    typedef struct packed {
        logic               col;
        logic [2:0]         neg;
        logic [2:0][DW-1:0] vrel;
        logic [CW-1:0]      pen;
        in_item_t           io;
    } div_side_t;

    // signed component k of a packed vector
    function automatic logic signed [CW-1:0] get_comp(input logic [FIELD_W-1:0] f,
                                                      input int unsigned k);
        return $signed(f[k*CW +: CW]);
    endfunction

    // divide by 2^k, round to nearest, ties away from zero
    function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] x,
                                                     input int unsigned k);
        logic [47:0] mag;
        mag = x[47] ? 48'(-x) : 48'(x);
        mag = (mag + (48'd1 << (k - 1))) >> k;
        return x[47] ? -$signed(mag) : $signed(mag);
    endfunction

    // clamp to the component range
    function automatic logic [CW-1:0] sat_comp(input logic signed [31:0] v);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = 32'sd1 <<< (CW - 1);
        lo = -hi;
        hi = hi - 32'sd1;
        if (v > hi)
            return hi[CW-1:0];
        else if (v < lo)
            return lo[CW-1:0];
        else
            return v[CW-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/spcr_dly.sv
// enabled delay line that keeps side data aligned with a pipelined unit
`default_nettype none

module spcr_dly #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         clk,
    input  logic         adv,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] dly_reg [N];

    // shift one stage per advance
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dly_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[N-1];

endmodule

`default_nettype wire

>>> rtl/spcr_isqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module spcr_isqrt import spcr_pkg::*; (
    input  logic            clk,
    input  logic            adv,
    input  logic [SQ_W-1:0] val,
    output logic [CW-1:0]   root
);

    logic [CW+2:0]   rem_reg  [SQ_STEPS];
    logic [CW-1:0]   root_reg [SQ_STEPS];
    logic [SQ_W-1:0] val_reg  [SQ_STEPS];

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_stage
        logic [CW+2:0]   rem_prv;
        logic [CW-1:0]   root_prv;
        logic [SQ_W-1:0] val_prv;
        logic [CW+2:0]   rem_sh;
        logic [CW+2:0]   trial;
        logic            ge;

        if (g == 0)
        begin : g_first
            assign rem_prv  = '0;
            assign root_prv = '0;
            assign val_prv  = val;
        end
        else
        begin : g_next
            assign rem_prv  = rem_reg[g-1];
            assign root_prv = root_reg[g-1];
            assign val_prv  = val_reg[g-1];
        end

        // bring down the next bit pair and try the next root bit
        always_comb
        begin
            rem_sh = {rem_prv[CW:0], val_prv[2*(SQ_STEPS-1-g) +: 2]};
            trial  = {1'b0, root_prv, 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[g] <= {root_prv[CW-2:0], ge};
                val_reg[g]  <= val_prv;
            end
        end
    end

    assign root = root_reg[SQ_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/spcr_div.sv
// pipelined restoring divider for one normal component, one quotient bit per stage
`default_nettype none

module spcr_div import spcr_pkg::*; (
    input  logic                 clk,
    input  logic                 adv,
    input  logic [CW-1:0]        mag,
    input  logic [CW-1:0]        den,
    output logic [DIV_STEPS-1:0] quo
);

    logic [CW-1:0]        rem_reg [DIV_STEPS];
    logic [CW-1:0]        den_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_stage
        logic [CW-1:0]        rem_prv;
        logic [CW-1:0]        den_prv;
        logic [DIV_STEPS-1:0] quo_prv;
        logic                 nbit;
        logic [CW:0]          rem_sh;
        logic                 ge;

        // the magnitude is never above the divisor, so the top bits start below it
        if (g == 0)
        begin : g_first
            assign rem_prv = {1'b0, mag[CW-1:1]};
            assign den_prv = den;
            assign quo_prv = '0;
            assign nbit    = mag[0];
        end
        else
        begin : g_next
            assign rem_prv = rem_reg[g-1];
            assign den_prv = den_reg[g-1];
            assign quo_prv = quo_reg[g-1];
            assign nbit    = 1'b0;
        end

        // shift in the next dividend bit and subtract when it fits
        always_comb
        begin
            rem_sh = {rem_prv, nbit};
            ge     = (rem_sh >= {1'b0, den_prv});
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g] <= ge ? CW'(rem_sh - {1'b0, den_prv}) : rem_sh[CW-1:0];
                den_reg[g] <= den_prv;
                quo_reg[g] <= {quo_prv[DIV_STEPS-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/sphere_pair_collision_resolve_unit.sv
// Sphere pair collision resolver, top level.
// Request channel req_valid/req_ready/req carries one sphere pair per item; response
// channel rsp_valid/rsp_ready/rsp returns one result item per request, in order.
// The restitution register is written through cfg_valid/cfg_ready/cfg_data; cfg_ready
// is always high, and writes are meant for times when no item is in flight.
// From request acceptance to rsp_valid an item passes through three stages of
// difference, square and compare, 21 stages of square root (one root bit each),
// 17 stages of division for the normal (one quotient bit each) and six stages of
// products, rounding and saturation. Throughput is one item per cycle unless stalled.
// The whole pipeline advances together: when rsp_valid is high and rsp_ready is
// low every stage holds and req_ready drops, so no item is lost or repeated.
// Reset clears all valid bits and loads restitution with 205 (about 0.8).
// Pairs that do not overlap, or whose centers coincide, come back unchanged
// with collided low.
`default_nettype none

module sphere_pair_collision_resolve_unit import spcr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  in_item_t          req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output out_item_t         rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [REST_W-1:0] cfg_data
);

`include "sphere_pair_collision_resolve_unit_defines.svh"

    logic                    adv;
    logic [PIPE_DEPTH-1:0]   valid_reg;
    logic [PIPE_DEPTH-1:0]   valid_next;
    logic [REST_W-1:0]       restitution_reg;
    logic [REST_W-1:0]       restitution_next;

    // stage 1
    logic [2:0][DW-1:0]      d1_reg;
    logic [2:0][DW-1:0]      vrel1_reg;
    logic [CW-1:0]           rsum1_reg;
    in_item_t                io1_reg;
    // stage 2
    logic [2:0][SQ_W-1:0]    sq2_reg;
    logic [SQ_W-1:0]         rsq2_reg;
    logic [2:0][DW-1:0]      d2_reg;
    logic [2:0][DW-1:0]      vrel2_reg;
    logic [CW-1:0]           rsum2_reg;
    in_item_t                io2_reg;
    // stage 3
    logic [SQ_W+1:0]         dsum;
    logic [SQ_W-1:0]         dist2_3_reg;
    root_side_t              side3_reg;
    // root and divider outputs
    logic [CW-1:0]           root;
    root_side_t              side_r;
    logic [2:0][CW-1:0]      mag_r;
    div_side_t               side_d_in;
    div_side_t               side_d;
    logic [2:0][DIV_STEPS-1:0] quo;
    // stage 42
    logic signed [NW-1:0]    n42_reg [3];
    logic signed [39:0]      pv42_reg [3];
    logic signed [39:0]      pc42_reg [3];
    logic                    col42_reg;
    in_item_t                io42_reg;
    // stage 43
    logic signed [25:0]      vn43_reg;
    logic signed [DW-1:0]    corr43_reg [3];
    logic signed [NW-1:0]    n43_reg [3];
    logic                    col43_reg;
    in_item_t                io43_reg;
    // stage 44
    logic [REST_W+1:0]       gain;
    logic signed [REST_W+1:0] neg_gain;
    logic signed [36:0]      pj44_reg;
    logic signed [DW-1:0]    corr44_reg [3];
    logic signed [NW-1:0]    n44_reg [3];
    logic                    col44_reg;
    in_item_t                io44_reg;
    // stage 45
    logic signed [27:0]      j45_reg;
    logic signed [DW-1:0]    corr45_reg [3];
    logic signed [NW-1:0]    n45_reg [3];
    logic                    col45_reg;
    in_item_t                io45_reg;
    // stage 46
    logic signed [45:0]      pi46_reg [3];
    logic signed [DW-1:0]    corr46_reg [3];
    logic                    col46_reg;
    in_item_t                io46_reg;
    // output stage
    out_item_t               rsp_reg;
    out_item_t               rsp_next;

    // pipeline advances unless a finished item is waiting
    assign adv       = !valid_reg[PIPE_DEPTH-1] || rsp_ready;
    assign req_ready = adv;
    assign cfg_ready = 1'b1;
    assign rsp_valid = valid_reg[PIPE_DEPTH-1];
    assign rsp       = rsp_reg;

    // valid bits and restitution register
    always_comb
    begin
        valid_next       = adv ? {valid_reg[PIPE_DEPTH-2:0], req_valid} : valid_reg;
        restitution_next = cfg_valid ? cfg_data : restitution_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            restitution_reg <= REST_RESET;
        end
        else
        begin
            valid_reg       <= valid_next;
            restitution_reg <= restitution_next;
        end
    end

    // stage 1: center difference, relative velocity, radius sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d1_reg[k]    <= DW'(get_comp(req.pos_b, k)) - DW'(get_comp(req.pos_a, k));
                vrel1_reg[k] <= DW'(get_comp(req.vel_b, k)) - DW'(get_comp(req.vel_a, k));
            end
            rsum1_reg <= {1'b0, req.radius_a} + {1'b0, req.radius_b};
            io1_reg   <= req;
        end
    end

    // stage 2: squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq2_reg[k] <= SQ_W'($signed(d1_reg[k]) * $signed(d1_reg[k]));
            end
            rsq2_reg  <= SQ_W'(rsum1_reg * rsum1_reg);
            d2_reg    <= d1_reg;
            vrel2_reg <= vrel1_reg;
            rsum2_reg <= rsum1_reg;
            io2_reg   <= io1_reg;
        end
    end

    // stage 3: squared distance and overlap test
    assign dsum = {2'b00, sq2_reg[0]} + {2'b00, sq2_reg[1]} + {2'b00, sq2_reg[2]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist2_3_reg    <= dsum[SQ_W-1:0];
            side3_reg.col  <= (dsum != '0) && (dsum < {2'b00, rsq2_reg});
            side3_reg.d    <= d2_reg;
            side3_reg.vrel <= vrel2_reg;
            side3_reg.rsum <= rsum2_reg;
            side3_reg.io   <= io2_reg;
        end
    end

    // square root of the squared distance
    spcr_isqrt u_isqrt (
        .clk  (clk),
        .adv  (adv),
        .val  (dist2_3_reg),
        .root (root)
    );

    spcr_dly #(.W($bits(root_side_t)), .N(SQ_STEPS)) u_root_dly (
        .clk  (clk),
        .adv  (adv),
        .din  (side3_reg),
        .dout (side_r)
    );

    // magnitudes for the dividers and penetration depth
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_r[k]           = side_r.d[k][DW-1] ? CW'(-side_r.d[k]) : side_r.d[k][CW-1:0];
            side_d_in.neg[k]   = side_r.d[k][DW-1];
        end
        side_d_in.col  = side_r.col;
        side_d_in.vrel = side_r.vrel;
        side_d_in.pen  = side_r.rsum - root;
        side_d_in.io   = side_r.io;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        spcr_div u_div (
            .clk (clk),
            .adv (adv),
            .mag (mag_r[k]),
            .den (root),
            .quo (quo[k])
        );
    end

    spcr_dly #(.W($bits(div_side_t)), .N(DIV_STEPS)) u_div_dly (
        .clk  (clk),
        .adv  (adv),
        .din  (side_d_in),
        .dout (side_d)
    );

    // stage 42: signed normal, velocity and correction products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [NW-1:0] nk;
                nk = side_d.neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
                n42_reg[k]  <= nk;
                pv42_reg[k] <= 40'($signed(side_d.vrel[k]) * nk);
                pc42_reg[k] <= 40'(nk * $signed({1'b0, side_d.pen}));
            end
            col42_reg <= side_d.col;
            io42_reg  <= side_d.io;
        end
    end

    // stage 43: normal velocity and rounded corrections
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vn43_reg <= 26'(rnd_shift(48'(42'(pv42_reg[0]) + 42'(pv42_reg[1])
                                         + 42'(pv42_reg[2])), NORM_BITS));
            for (int k = 0; k < 3; k++)
            begin
                corr43_reg[k] <= DW'(rnd_shift(48'(pc42_reg[k]), NORM_BITS + 1));
                n43_reg[k]    <= n42_reg[k];
            end
            col43_reg <= col42_reg;
            io43_reg  <= io42_reg;
        end
    end

    // stage 44: scale by -(1 + e)
    assign gain     = (REST_W+2)'(1 << REST_BITS) + (REST_W+2)'(restitution_reg);
    assign neg_gain = -$signed(gain);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pj44_reg   <= 37'(vn43_reg * neg_gain);
            corr44_reg <= corr43_reg;
            n44_reg    <= n43_reg;
            col44_reg  <= col43_reg;
            io44_reg   <= io43_reg;
        end
    end

    // stage 45: impulse magnitude
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j45_reg    <= 28'(rnd_shift(48'(pj44_reg), REST_BITS + 1));
            corr45_reg <= corr44_reg;
            n45_reg    <= n44_reg;
            col45_reg  <= col44_reg;
            io45_reg   <= io44_reg;
        end
    end

    // stage 46: impulse along the normal
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pi46_reg[k] <= 46'(j45_reg * n45_reg[k]);
            end
            corr46_reg <= corr45_reg;
            col46_reg  <= col45_reg;
            io46_reg   <= io45_reg;
        end
    end

    // output stage: apply corrections and impulses with saturation
    always_comb
    begin
        logic signed [29:0] imp;
        rsp_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            imp = 30'(rnd_shift(48'(pi46_reg[k]), NORM_BITS));
            rsp_next.new_pos_a[k*CW +: CW] =
                sat_comp(32'(get_comp(io46_reg.pos_a, k)) - 32'(corr46_reg[k]));
            rsp_next.new_pos_b[k*CW +: CW] =
                sat_comp(32'(get_comp(io46_reg.pos_b, k)) + 32'(corr46_reg[k]));
            rsp_next.new_vel_a[k*CW +: CW] =
                sat_comp(32'(get_comp(io46_reg.vel_a, k)) - 32'(imp));
            rsp_next.new_vel_b[k*CW +: CW] =
                sat_comp(32'(get_comp(io46_reg.vel_b, k)) + 32'(imp));
        end
        rsp_next.collided = 1'b1;
        if (!col46_reg)
        begin
            rsp_next.new_pos_a = io46_reg.pos_a;
            rsp_next.new_vel_a = io46_reg.vel_a;
            rsp_next.new_pos_b = io46_reg.pos_b;
            rsp_next.new_vel_b = io46_reg.vel_b;
            rsp_next.collided  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // checks
    `SPCR_ASSERT_NEXT(a_item_reaches_output, valid_reg[PIPE_DEPTH-2] && adv, rsp_valid,
        "item in last stage did not reach the output")
    `SPCR_ASSERT_NEXT(a_stall_freezes_valids, !adv, $stable(valid_reg),
        "pipeline valid bits moved during a stall")
    `SPCR_ASSERT_NOW(a_stall_blocks_input, rsp_valid && !rsp_ready, !req_ready,
        "request taken while the output is stalled")

endmodule

`default_nettype wire
